FILE: design/lzss_token_decoder_assert.svh
// Assertion macros for the checker of the token decoder.
`ifndef LZSS_TOKEN_DECODER_ASSERT_SVH
`define LZSS_TOKEN_DECODER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LZTD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LZTD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/lztd_pkg.sv
package lztd_pkg;

  localparam int DIST_BITS     = 12;
  localparam int LEN_BITS      = 4;
  localparam int HISTORY_DEPTH = 4096;

  localparam int PTR_W = $clog2(HISTORY_DEPTH);
  localparam int CNT_W = PTR_W + 1;
  localparam int MAX_DC_W = (DIST_BITS > CNT_W) ? DIST_BITS : CNT_W;
  localparam int CMP_W = (MAX_DC_W > LEN_BITS) ? MAX_DC_W : LEN_BITS;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_OOB   = 2'd2
  } lztd_status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic emit_lit;
    logic emit_status;
    logic start_read;
    logic next_read;
    logic emit_copy;
  } lztd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_ref;
    logic oob;
    logic empty;
    logic last_byte;
    logic out_free;
  } lztd_stat_t;

endpackage

FILE: design/lztd_ram.sv
module lztd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: design/lztd_ctrl.sv
module lztd_ctrl import lztd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  lztd_stat_t stat,
  output lztd_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_DECIDE = 3'b010,
    S_EMIT   = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.out_free) begin
          if (!stat.is_ref) begin
            cmd.emit_lit = 1'b1;
            state_next   = S_IDLE;
          end else if (stat.oob || stat.empty) begin
            cmd.emit_status = 1'b1;
            state_next      = S_IDLE;
          end else begin
            cmd.start_read = 1'b1;
            state_next     = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit_copy = 1'b1;
          if (stat.last_byte) begin
            state_next = S_IDLE;
          end else begin
            cmd.next_read = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: design/lztd_dp.sv
module lztd_dp import lztd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  lztd_cmd_t            cmd,
  output lztd_stat_t           stat,
  input  logic                 kind,
  input  logic [7:0]           literal_byte,
  input  logic [DIST_BITS-1:0] ref_distance,
  input  logic [LEN_BITS-1:0]  ref_length,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_byte,
  output logic [1:0]           status,
  output logic                 last
);

  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(HISTORY_DEPTH);

  // Token captured at acceptance.
  logic                 kind_r;
  logic [7:0]           lit_r;
  logic [DIST_BITS-1:0] dist_r;
  logic [LEN_BITS-1:0]  len_r;

  logic [PTR_W-1:0]     wp;
  logic [CNT_W-1:0]     count;
  logic [PTR_W-1:0]     src;
  logic [LEN_BITS-1:0]  remaining;

  lztd_status_t         status_r;

  logic [CMP_W-1:0]     dist_x;
  logic [CMP_W-1:0]     len_x;
  logic [CMP_W-1:0]     count_x;
  logic [CMP_W-1:0]     src_diff;
  logic [PTR_W-1:0]     rd_addr;
  logic                 rd_en;
  logic [7:0]           rd_data;
  logic                 wr_en;
  logic [7:0]           wr_data;

  assign dist_x   = CMP_W'(dist_r);
  assign len_x    = CMP_W'(len_r);
  assign count_x  = CMP_W'(count);
  assign src_diff = CMP_W'(wp) - dist_x;

  assign stat.is_ref    = kind_r;
  assign stat.oob       = (dist_x > count_x) || (len_x > dist_x);
  assign stat.empty     = (len_r == '0);
  assign stat.last_byte = (remaining == LEN_BITS'(1));
  assign stat.out_free  = !out_valid || out_ready;

  assign rd_en   = cmd.start_read || cmd.next_read;
  assign rd_addr = cmd.start_read ? src_diff[PTR_W-1:0] : src + PTR_W'(1);
  assign wr_en   = cmd.emit_lit || cmd.emit_copy;
  assign wr_data = cmd.emit_lit ? lit_r : rd_data;

  lztd_ram #(
    .WIDTH (8),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wp),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= kind;
      lit_r  <= literal_byte;
      dist_r <= ref_distance;
      len_r  <= ref_length;
    end
    if (rd_en) begin
      src <= rd_addr;
    end
    if (cmd.start_read) begin
      remaining <= len_r;
    end else if (cmd.emit_copy) begin
      remaining <= remaining - LEN_BITS'(1);
    end
    if (wr_en) begin
      out_byte <= wr_data;
      status_r <= ST_OK;
      last     <= cmd.emit_lit || stat.last_byte;
    end else if (cmd.emit_status) begin
      out_byte <= '0;
      status_r <= stat.oob ? ST_OOB : ST_EMPTY;
      last     <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp        <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        wp <= wp + PTR_W'(1);
        if (count != FULL_COUNT) begin
          count <= count + CNT_W'(1);
        end
      end
      if (wr_en || cmd.emit_status) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status = status_r;

endmodule

FILE: design/lzss_token_decoder.sv
// LZSS token decoder. Each input transaction carries one parsed token: a literal
// byte (kind 0) or a back-reference of distance and length (kind 1). A literal is
// emitted and appended to a 4096-byte history. A reference copies its length in
// bytes from the history, starting distance bytes back from the current end, and
// emits and appends each byte, with last set on the final one. A reference of
// length zero gives one result with status 1; a reference whose distance exceeds
// the bytes decoded so far (counted up to 4096) or whose length exceeds its
// distance gives one result with status 2, also when its length is zero, and
// leaves the history untouched. Both carry a zero byte and last set. In order, a
// literal, an empty reference and a rejected reference pass from the token
// register through the check state into the output register; a reference is
// taken, checked while its first history read starts, and then copied at one
// byte per cycle while the output is not stalled. That rate is set by the single
// read port of the history RAM, whose read data is registered. The block takes
// one token at a time, but accepts the next token while the last result of the
// previous one still waits in the output register; a stalled output holds the
// copy until it is taken. The history has no reset and needs no clearing pass,
// because the bounds check only lets a copy read bytes that were written before.
module lzss_token_decoder import lztd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 kind,
  input  logic [7:0]           literal_byte,
  input  logic [DIST_BITS-1:0] ref_distance,
  input  logic [LEN_BITS-1:0]  ref_length,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_byte,
  output logic [1:0]           status,
  output logic                 last
);

  lztd_cmd_t  cmd;
  lztd_stat_t stat;

  // The controller sequences each token; it never touches the payload itself.
  lztd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the token, the pointers, the history RAM and the output
  // register.
  lztd_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .kind         (kind),
    .literal_byte (literal_byte),
    .ref_distance (ref_distance),
    .ref_length   (ref_length),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .status       (status),
    .last         (last)
  );

endmodule

FILE: design/lztd_checker.sv
`include "lzss_token_decoder_assert.svh"

module lztd_checker import lztd_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [7:0]           out_byte,
  input logic [1:0]           status,
  input logic                 last
);

  // A result that is not taken stays put.
  `LZTD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_byte) && $stable(status) && $stable(last),
    "result changed while stalled")

  // Empty and rejected references give a single zero result.
  `LZTD_ASSERT_NOW(a_flag_result, out_valid && (status != ST_OK),
    (out_byte == 8'd0) && last && ((status == ST_EMPTY) || (status == ST_OOB)),
    "flagged result is not a lone zero result")

  // Only one token is worked on at a time.
  `LZTD_ASSERT_NEXT(a_one_token, in_valid && in_ready, !in_ready,
    "token accepted while another is being decoded")

endmodule

bind lzss_token_decoder lztd_checker u_lztd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_byte  (out_byte),
  .status    (status),
  .last      (last)
);

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import lztd_pkg::*;

  // Field extremes and run sizing. The random part is sized so that the
  // history fills past its depth, which exercises the pointer wrap and the
  // saturation of the decoded byte count.
  localparam int MAX_DIST     = (1 << DIST_BITS) - 1;
  localparam int MAX_LEN      = (1 << LEN_BITS) - 1;
  localparam int RANDOM_ITEMS = 388;
  localparam int SETTLE       = 24;
  localparam int CYCLE_LIMIT  = 800000;

  // One decoded result as it leaves the block.
  typedef struct packed {
    logic [7:0]   data;
    lztd_status_t code;
    logic         tail;
  } decoded_t;

  // The scoreboard keeps its own copy of the history window, the write
  // pointer and the count of bytes decoded so far. Each accepted token is
  // decoded here into the results it ought to produce, and these wait in
  // order until the block delivers them.
  class token_scoreboard;
    logic [7:0]       window [HISTORY_DEPTH];
    logic [PTR_W-1:0] wr_ptr;
    logic [CNT_W-1:0] filled;
    decoded_t         pending_q[$];
    int               errors;

    function new();
      wr_ptr = '0;
      filled = '0;
      errors = 0;
    endfunction

    function void append(logic [7:0] value);
      window[wr_ptr] = value;
      wr_ptr = wr_ptr + 1'b1;
      if (filled < HISTORY_DEPTH) begin
        filled = filled + 1'b1;
      end
    endfunction

    function void note_token(logic k, logic [7:0] lit, logic [DIST_BITS-1:0] distance,
                             logic [LEN_BITS-1:0] len);
      logic [PTR_W-1:0] src;
      logic [7:0]       value;
      if (k == 1'b0) begin
        append(lit);
        pending_q.push_back('{data: lit, code: ST_OK, tail: 1'b1});
      end else if (distance > filled || len > distance) begin
        // A reference that reaches before the start of the data, or that
        // would overlap its own output, is rejected without touching state.
        pending_q.push_back('{data: 8'h00, code: ST_OOB, tail: 1'b1});
      end else if (len == 0) begin
        pending_q.push_back('{data: 8'h00, code: ST_EMPTY, tail: 1'b1});
      end else begin
        src = wr_ptr - distance;
        for (int i = 0; i < len; i++) begin
          value = window[src];
          src = src + 1'b1;
          append(value);
          pending_q.push_back('{data: value, code: ST_OK, tail: (i == len - 1)});
        end
      end
    endfunction

    task flag_mismatch(string what);
      errors++;
      if (errors <= 40) begin
        $display("mismatch %0d at %0t: %s", errors, $time, what);
      end
    endtask

    task check_result(logic [7:0] data, logic [1:0] code, logic tail);
      decoded_t want;
      if (pending_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result byte %02h status %0d last %0b",
                                data, code, tail));
      end else begin
        want = pending_q.pop_front();
        if (data !== want.data || code !== want.code || tail !== want.tail) begin
          flag_mismatch($sformatf("got byte %02h status %0d last %0b, want %02h %0d %0b",
                                  data, code, tail, want.data, want.code, want.tail));
        end
      end
    endtask
  endclass

  // Clock, reset and every block input start at known values.
  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 in_valid     = 1'b0;
  logic                 kind         = 1'b0;
  logic [7:0]           literal_byte = '0;
  logic [DIST_BITS-1:0] ref_distance = '0;
  logic [LEN_BITS-1:0]  ref_length   = '0;
  logic                 out_ready    = 1'b0;
  logic                 in_ready;
  logic                 out_valid;
  logic [7:0]           out_byte;
  logic [1:0]           status;
  logic                 last;

  token_scoreboard sb = new();
  int cycle_count = 0;

  // Each side alternates between steady stretches with no idling and
  // stretches where every transaction is preceded by a random pause.
  int send_run_left = 0;
  bit send_steady   = 1'b0;
  int take_run_left = 0;
  bit take_steady   = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  lzss_token_decoder u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .literal_byte (literal_byte),
    .ref_distance (ref_distance),
    .ref_length   (ref_length),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .status       (status),
    .last         (last)
  );

  function automatic int draw_wait(inout int run_left, inout bit steady);
    if (run_left == 0) begin
      steady   = ($urandom_range(0, 3) == 0);
      run_left = $urandom_range(8, 40);
    end
    run_left--;
    return steady ? 0 : $urandom_range(0, 18);
  endfunction

  // Offers one token and returns at the edge where the transaction is taken.
  // The caller is always at a rising edge, so valid is either held high for
  // a back-to-back transaction or lowered once and raised after the pause;
  // it never gets two assignments in one time step.
  task send_token(logic k, logic [7:0] lit, logic [DIST_BITS-1:0] distance,
                  logic [LEN_BITS-1:0] len);
    int pause;
    pause = draw_wait(send_run_left, send_steady);
    if (pause > 0) begin
      in_valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    in_valid     <= 1'b1;
    kind         <= k;
    literal_byte <= lit;
    ref_distance <= distance;
    ref_length   <= len;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_token(k, lit, distance, len);
  endtask

  // Result side: outside the steady stretches, ready is withdrawn for a random pause
  // before each result, and every transaction taken is checked against the scoreboard.
  initial begin
    int pause;
    while (rst) @(posedge clk);
    forever begin
      pause = draw_wait(take_run_left, take_steady);
      if (pause > 0) begin
        out_ready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      sb.check_result(out_byte, status, last);
    end
  end

  // A hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int  cap;
    int  len;
    int  distance;
    int  pick;
    bit  saturated;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed opening. With nothing decoded yet, a zero-length reference of
    // zero distance is in bounds and so comes back empty, whereas any other
    // distance is out of bounds, as is a zero distance with a nonzero length.
    send_token(1'b1, 8'h3c, 0, 0);
    send_token(1'b1, 8'hc3, 1, 0);
    send_token(1'b1, 8'h00, 0, 1);
    // Literals at both extremes and with alternating bits.
    send_token(1'b0, 8'h00, DIST_BITS'(MAX_DIST), LEN_BITS'(MAX_LEN));
    send_token(1'b0, 8'hff, 0, 0);
    send_token(1'b0, 8'ha5, 12'h5a5, 4'ha);
    send_token(1'b0, 8'h5a, 12'ha5a, 4'h5);
    // A copy of the whole history, then a length beyond its distance, then
    // the largest reference while only a few bytes exist.
    send_token(1'b1, 8'hff, 4, 4);
    send_token(1'b1, 8'h00, 3, 4);
    send_token(1'b1, 8'h00, DIST_BITS'(MAX_DIST), LEN_BITS'(MAX_LEN));
    // Growing copies, including the longest length with its distance equal
    // to it and with a distance one past it.
    send_token(1'b1, 8'h00, 8, 8);
    send_token(1'b1, 8'h00, 16, LEN_BITS'(MAX_LEN));
    send_token(1'b1, 8'h00, DIST_BITS'(MAX_LEN), LEN_BITS'(MAX_LEN));
    send_token(1'b1, 8'h00, 1, 1);
    // Empty reference well inside the data.
    send_token(1'b1, 8'h00, 5, 0);
    // The oldest byte is reachable, one further back is not.
    send_token(1'b1, 8'h00, DIST_BITS'(sb.filled), 1);
    send_token(1'b1, 8'h00, DIST_BITS'(sb.filled + 1'b1), 1);
    send_token(1'b1, 8'h00, 2, LEN_BITS'(MAX_LEN));

    // Random part. Until the history has filled, most transactions are valid
    // long copies so that the write pointer wraps and the decoded count
    // saturates; after that the mix widens towards literals, empty
    // references and unconstrained noise, much of which is out of bounds.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      saturated = (sb.filled >= HISTORY_DEPTH);
      cap  = (sb.filled > MAX_DIST) ? MAX_DIST : sb.filled;
      pick = $urandom_range(0, 99);
      if (pick < (saturated ? 20 : 8) || cap == 0) begin
        send_token(1'b0, 8'($urandom), DIST_BITS'($urandom), LEN_BITS'($urandom));
      end else if (pick < (saturated ? 32 : 14)) begin
        send_token(1'($urandom_range(0, 1)), 8'($urandom), DIST_BITS'($urandom),
                   LEN_BITS'($urandom));
      end else if (pick < (saturated ? 40 : 18)) begin
        send_token(1'b1, 8'($urandom), DIST_BITS'($urandom_range(0, cap)), 0);
      end else begin
        len = (!saturated && $urandom_range(0, 99) < 85) ? MAX_LEN
                                                          : $urandom_range(1, MAX_LEN);
        if (len > cap) begin
          len = cap;
        end
        case ($urandom_range(0, 3))
          0: distance = cap;
          1: distance = len;
          default: distance = $urandom_range(len, cap);
        endcase
        send_token(1'b1, 8'($urandom), DIST_BITS'(distance), LEN_BITS'(len));
      end
    end

    // Directed close: the farthest distance with the longest and with a zero
    // length, which are in bounds once the history is full.
    send_token(1'b1, 8'h00, DIST_BITS'(MAX_DIST), LEN_BITS'(MAX_LEN));
    send_token(1'b1, 8'hff, DIST_BITS'(MAX_DIST), 0);
    in_valid <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/lztd_pkg.sv
design/lztd_ram.sv
design/lztd_ctrl.sv
design/lztd_dp.sv
design/lzss_token_decoder.sv
design/lztd_checker.sv
tb/sv/testbench.sv
